FILE: rtl/flc_pkg.sv
// shared types and codes of the full linear convolution unit
package flc_pkg;

  // width of the kernel index carried with a command, enough for the largest kernel
  localparam int CNT_W = 9;

  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic {
    OP_COEF,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [15:0]      value;
    logic             last;
    logic [CNT_W-1:0] index;
  } cmd_t;

endpackage

FILE: rtl/flc_front.sv
// front end: accepts input transactions, tracks the kernel load and issues commands
module flc_front #(
  parameter int TAPS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [15:0]       in_value,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output flc_pkg::cmd_t     q_cmd
);

  localparam int CW = $clog2(TAPS + 1);

  logic [CW-1:0] tap_count_r, tap_count_nxt;
  logic          loading_r, loading_nxt;
  logic [CW-1:0] cur_count;
  logic          accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cur_count = loading_r ? tap_count_r : '0;

  always_comb begin
    tap_count_nxt = tap_count_r;
    loading_nxt   = loading_r;
    q_push        = 1'b0;
    q_cmd.op      = flc_pkg::OP_COEF;
    q_cmd.value   = in_value;
    q_cmd.last    = in_last;
    q_cmd.index   = flc_pkg::CNT_W'(tap_count_r);
    if (accept) begin
      if (in_kind == flc_pkg::KIND_COEF) begin
        loading_nxt   = !in_last;
        tap_count_nxt = cur_count;
        if (cur_count < CW'(TAPS)) begin
          q_push        = 1'b1;
          q_cmd.index   = flc_pkg::CNT_W'(cur_count);
          tap_count_nxt = cur_count + CW'(1);
        end
      end else begin
        loading_nxt = 1'b0;
        if (tap_count_r != '0) begin
          q_push   = 1'b1;
          q_cmd.op = flc_pkg::OP_SAMPLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= '0;
      loading_r   <= 1'b0;
    end else begin
      tap_count_r <= tap_count_nxt;
      loading_r   <= loading_nxt;
    end
  end

endmodule

FILE: rtl/flc_queue.sv
// two-entry command queue between front end and back end
module flc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  flc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output flc_pkg::cmd_t pop_cmd
);

  flc_pkg::cmd_t entries_r [2];
  logic          wr_r;
  logic          rd_r;
  logic [1:0]    cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign pop_cmd = entries_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/flc_back.sv
// back end: coefficient and sample memories, shared multiply-accumulate, saturation
module flc_back #(
  parameter int TAPS      = 16,
  parameter int DATA_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          signed_mode,
  input  logic          q_valid,
  input  flc_pkg::cmd_t q_cmd,
  output logic          q_pop,
  input  logic          out_ready,
  output logic          out_valid,
  output logic [15:0]   out_result,
  output logic          out_saturated,
  output logic          out_end_of_output
);

  localparam int AW   = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CW   = $clog2(TAPS + 1);
  localparam int DW   = DATA_BITS;
  localparam int PW   = 2 * DATA_BITS + 2;
  localparam int ACCW = PW + CW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
  localparam logic signed [ACCW-1:0] SMAX = (ACCW'(1) <<< (DATA_BITS - 1)) - ACCW'(1);
  localparam logic signed [ACCW-1:0] SMIN = -SMAX - ACCW'(1);
  localparam logic signed [ACCW-1:0] UMAX = (ACCW'(1) <<< DATA_BITS) - ACCW'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } state_t;

  logic [DW-1:0] coef_mem [TAPS];
  logic [DW-1:0] smp_mem  [TAPS];

  state_t               state_r, state_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        ntaps_r, ntaps_nxt;
  logic                 last_r, last_nxt;
  logic [AW-1:0]        k_r, k_nxt;
  logic [AW-1:0]        start_r, start_nxt;
  logic [AW-1:0]        i_r, i_nxt;
  logic [AW-1:0]        sa_r, sa_nxt;
  logic                 s1_vld_r, s1_vld_nxt;
  logic                 s1_term_r, s1_term_nxt;
  logic                 s2_vld_r, s2_vld_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [DW-1:0]        out_res_r, out_res_nxt;
  logic                 out_sat_r, out_sat_nxt;
  logic                 out_eoo_r, out_eoo_nxt;
  logic [DW-1:0]        coef_rd_r;
  logic [DW-1:0]        smp_rd_r;

  logic                 coef_we;
  logic                 smp_we;
  logic [DW-1:0]        wdata;
  logic                 term;
  logic                 last_tap;
  logic                 final_out;
  logic                 pipe_empty;
  logic                 out_free;
  logic signed [DW:0]   opa;
  logic signed [DW:0]   opb;
  logic [DW-1:0]        sat_res;
  logic                 sat_flag;
  logic [AW-1:0]        start_inc;

  assign wdata      = DW'(32'(q_cmd.value));
  assign term       = (CW'(i_r) >= CW'(k_r)) && ((CW'(i_r) - CW'(k_r)) < fill_r);
  assign last_tap   = (CW'(i_r) + CW'(1)) == ntaps_r;
  assign final_out  = !last_r || ((CW'(k_r) + CW'(1)) == ntaps_r);
  assign pipe_empty = !s1_vld_r && !s2_vld_r;
  assign out_free   = !out_vld_r || out_ready;
  assign start_inc  = (start_r == LAST_ADDR) ? '0 : start_r + AW'(1);

  // operands widened by one bit per mode, zero for taps outside the delay line
  always_comb begin
    opa = '0;
    opb = '0;
    if (s1_term_r) begin
      opa = $signed({signed_mode & coef_rd_r[DW-1], coef_rd_r});
      opb = $signed({signed_mode & smp_rd_r[DW-1], smp_rd_r});
    end
  end

  always_comb begin
    sat_flag = 1'b0;
    sat_res  = acc_r[DW-1:0];
    if (signed_mode) begin
      if (acc_r > SMAX) begin
        sat_flag = 1'b1;
        sat_res  = SMAX[DW-1:0];
      end else if (acc_r < SMIN) begin
        sat_flag = 1'b1;
        sat_res  = SMIN[DW-1:0];
      end
    end else if (acc_r > UMAX) begin
      sat_flag = 1'b1;
      sat_res  = UMAX[DW-1:0];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    fill_nxt    = fill_r;
    ntaps_nxt   = ntaps_r;
    last_nxt    = last_r;
    k_nxt       = k_r;
    start_nxt   = start_r;
    i_nxt       = i_r;
    sa_nxt      = sa_r;
    q_pop       = 1'b0;
    coef_we     = 1'b0;
    smp_we      = 1'b0;
    s1_vld_nxt  = 1'b0;
    s1_term_nxt = term;
    s2_vld_nxt  = s1_vld_r;
    prod_nxt    = opa * opb;
    acc_nxt     = s2_vld_r ? acc_r + ACCW'(prod_r) : acc_r;
    out_vld_nxt = out_vld_r && !out_ready;
    out_res_nxt = out_res_r;
    out_sat_nxt = out_sat_r;
    out_eoo_nxt = out_eoo_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == flc_pkg::OP_COEF) begin
            coef_we  = 1'b1;
            fill_nxt = '0;
          end else begin
            smp_we    = 1'b1;
            start_nxt = wp_r;
            sa_nxt    = wp_r;
            wp_nxt    = (wp_r == LAST_ADDR) ? '0 : wp_r + AW'(1);
            fill_nxt  = (fill_r < CW'(TAPS)) ? fill_r + CW'(1) : fill_r;
            ntaps_nxt = CW'(q_cmd.index);
            last_nxt  = q_cmd.last;
            k_nxt     = '0;
            i_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        s1_vld_nxt = 1'b1;
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end else begin
          i_nxt  = i_r + AW'(1);
          sa_nxt = (sa_r == '0) ? LAST_ADDR : sa_r - AW'(1);
        end
      end
      ST_DRAIN: begin
        if (pipe_empty && out_free) begin
          out_vld_nxt = 1'b1;
          out_res_nxt = sat_res;
          out_sat_nxt = sat_flag;
          out_eoo_nxt = last_r && final_out;
          if (final_out) begin
            if (last_r) begin
              fill_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            start_nxt = start_inc;
            sa_nxt    = start_inc;
            i_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = ST_MAC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[AW'(q_cmd.index)] <= wdata;
    end
    if (smp_we) begin
      smp_mem[wp_r] <= wdata;
    end
    coef_rd_r <= coef_mem[i_r];
    smp_rd_r  <= smp_mem[sa_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      wp_r      <= '0;
      fill_r    <= '0;
      k_r       <= '0;
      i_r       <= '0;
      sa_r      <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      k_r       <= k_nxt;
      i_r       <= i_nxt;
      sa_r      <= sa_nxt;
      s1_vld_r  <= s1_vld_nxt;
      s2_vld_r  <= s2_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    ntaps_r   <= ntaps_nxt;
    last_r    <= last_nxt;
    start_r   <= start_nxt;
    s1_term_r <= s1_term_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    out_res_r <= out_res_nxt;
    out_sat_r <= out_sat_nxt;
    out_eoo_r <= out_eoo_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_result        = 16'(32'(out_res_r));
  assign out_saturated     = out_sat_r;
  assign out_end_of_output = out_eoo_r;

endmodule

FILE: rtl/full_linear_convolution_unit.sv
// top level of the full linear convolution unit
// Computes the full linear convolution of a sample stream with a kernel of up to TAPS
// coefficients. Coefficient transactions (in_kind 0) load the kernel from tap 0 upward,
// in_last closing the load; a sample transaction also closes it, and extra coefficients
// beyond TAPS are dropped. Each sample gives one output, and the last sample of a signal
// gives tap_count outputs in all, the final one flagged by out_end_of_output. Sums are
// exact and saturated to the DATA_BITS range of the mode in cfg_wdata (1 signed, 0
// unsigned; write only while idle). The back end writes a coefficient as it pops it; each
// output comes from the single shared multiply-accumulate walking the kernel, and the
// next command waits until the last output of the sample is registered. A two-entry queue
// and an output register let the input side run ahead while results wait to be taken.
module full_linear_convolution_unit #(
  parameter int TAPS      = 16,
  parameter int DATA_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [15:0] in_value,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result,
  output logic        out_saturated,
  output logic        out_end_of_output,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic          signed_mode_r;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  flc_pkg::cmd_t push_cmd;
  flc_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
    end else if (cfg_we) begin
      signed_mode_r <= cfg_wdata;
    end
  end

  flc_front #(
    .TAPS (TAPS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_kind  (in_kind),
    .in_value (in_value),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  flc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  flc_back #(
    .TAPS      (TAPS),
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .signed_mode       (signed_mode_r),
    .q_valid           (q_valid),
    .q_cmd             (pop_cmd),
    .q_pop             (q_pop),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_result        (out_result),
    .out_saturated     (out_saturated),
    .out_end_of_output (out_end_of_output)
  );

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  a_sample_needs_kernel: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && push_cmd.op == flc_pkg::OP_SAMPLE) |-> (push_cmd.index != '0))
    else $error("sample issued with no kernel loaded");
`endif

endmodule
